// File: sv/ddpt_pkg.sv
// ----------------------------------------------------------------------------
// ddpt_pkg
// Shared defaults for the drawdown period tracker and its checker.
// ----------------------------------------------------------------------------
package ddpt_pkg;

  localparam int EQUITY_BITS_DEF = 48;
  localparam int FRAC_BITS_DEF   = 16;
  localparam int COUNT_BITS_DEF  = 32;

endpackage

// File: sv/drawdown_period_tracker.sv
// ----------------------------------------------------------------------------
// drawdown_period_tracker
// Running-peak drawdown per bar in Q1.FRAC_BITS, drawdown period length and
// period peak, and series maximum drawdown.
// ----------------------------------------------------------------------------
//  channel | ports                                     | handshake
//  --------+-------------------------------------------+-------------------
//  input   | in_equity_value, in_series_end            | in_valid / in_stall
//  result  | out_drawdown_frac, out_period_closed,     | out_valid / out_stall
//          | out_period_length, out_period_peak_drawdown,
//          | out_series_max_drawdown, out_last_of_series
//
// A transaction is accepted in the idle state, then passes the prep state,
// FRAC_BITS + 1 steps of the shared restoring subtract/compare unit and the
// update state. A zero peak skips the division. in_stall is high from
// acceptance until the sequencer is idle again.
// The result sits in an output register; the next transaction is accepted
// while it waits, and the update cycle holds until that register is free.
// Reset (rst_n low, synchronous) clears all series state; no clearing pass.
// ----------------------------------------------------------------------------
module drawdown_period_tracker
  import ddpt_pkg::*;
#(
  parameter int EQUITY_BITS = EQUITY_BITS_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF,
  parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [EQUITY_BITS-1:0] in_equity_value,
  input  logic                   in_series_end,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [FRAC_BITS:0]     out_drawdown_frac,
  output logic                   out_period_closed,
  output logic [COUNT_BITS-1:0]  out_period_length,
  output logic [FRAC_BITS:0]     out_period_peak_drawdown,
  output logic [FRAC_BITS:0]     out_series_max_drawdown,
  output logic                   out_last_of_series
);

  localparam int CW = $clog2(FRAC_BITS + 1);
  localparam logic [CW-1:0]         LAST_STEP = CW'(FRAC_BITS);
  localparam logic [FRAC_BITS:0]    DD_ONE    = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [COUNT_BITS-1:0] CNT_MAX   = '1;
  localparam logic [COUNT_BITS-1:0] CNT_ONE   = COUNT_BITS'(1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_PREP = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_UPD  = 2'd3;

  logic [1:0]             state_r, state_nxt;
  logic [CW-1:0]          cnt_r, cnt_nxt;
  logic [EQUITY_BITS-1:0] eq_r, eq_nxt;
  logic                   last_r, last_nxt;
  logic [EQUITY_BITS:0]   rem_r, rem_nxt;
  logic [FRAC_BITS:0]     quo_r, quo_nxt;

  logic [EQUITY_BITS-1:0] peak_r, peak_nxt;
  logic                   first_r, first_nxt;
  logic [COUNT_BITS-1:0]  bars_r, bars_nxt;
  logic [FRAC_BITS:0]     open_pk_r, open_pk_nxt;
  logic [FRAC_BITS:0]     max_dd_r, max_dd_nxt;

  logic                   out_valid_r, out_valid_nxt;
  logic [FRAC_BITS:0]     o_dd_r, o_dd_nxt;
  logic                   o_closed_r, o_closed_nxt;
  logic [COUNT_BITS-1:0]  o_len_r, o_len_nxt;
  logic [FRAC_BITS:0]     o_ppk_r, o_ppk_nxt;
  logic [FRAC_BITS:0]     o_max_r, o_max_nxt;
  logic                   o_last_r, o_last_nxt;

  // shared subtract/compare unit
  logic                   sub_ge;
  logic [EQUITY_BITS:0]   sub_res;
  logic [EQUITY_BITS-1:0] prep_peak;
  logic                   is_zero;
  logic                   out_free;
  logic [FRAC_BITS:0]     open_upd;

  assign in_stall = (state_r != ST_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    sub_ge  = (rem_r >= {1'b0, peak_r});
    sub_res = sub_ge ? (rem_r - {1'b0, peak_r}) : rem_r;
  end

  always_comb begin
    if (first_r || eq_r > peak_r) begin
      prep_peak = eq_r;
    end else begin
      prep_peak = peak_r;
    end
    is_zero  = (peak_r != '0) && (eq_r == peak_r);
    open_upd = (quo_r > open_pk_r) ? quo_r : open_pk_r;
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    eq_nxt        = eq_r;
    last_nxt      = last_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    peak_nxt      = peak_r;
    first_nxt     = first_r;
    bars_nxt      = bars_r;
    open_pk_nxt   = open_pk_r;
    max_dd_nxt    = max_dd_r;
    out_valid_nxt = out_valid_r && out_stall;
    o_dd_nxt      = o_dd_r;
    o_closed_nxt  = o_closed_r;
    o_len_nxt     = o_len_r;
    o_ppk_nxt     = o_ppk_r;
    o_max_nxt     = o_max_r;
    o_last_nxt    = o_last_r;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          eq_nxt    = in_equity_value;
          last_nxt  = in_series_end;
          state_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        peak_nxt = prep_peak;
        if (first_r) begin
          bars_nxt    = '0;
          open_pk_nxt = '0;
          max_dd_nxt  = '0;
          first_nxt   = 1'b0;
        end
        rem_nxt = {1'b0, prep_peak - eq_r};
        quo_nxt = '0;
        cnt_nxt = '0;
        if (prep_peak == '0) begin
          quo_nxt   = DD_ONE;
          state_nxt = ST_UPD;
        end else begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        quo_nxt = {quo_r[FRAC_BITS-1:0], sub_ge};
        rem_nxt = {sub_res[EQUITY_BITS-1:0], 1'b0};
        cnt_nxt = cnt_r + CW'(1);
        if (cnt_r == LAST_STEP) begin
          state_nxt = ST_UPD;
        end
      end
      ST_UPD: begin
        if (out_free) begin
          o_dd_nxt     = quo_r;
          o_max_nxt    = (quo_r > max_dd_r) ? quo_r : max_dd_r;
          max_dd_nxt   = o_max_nxt;
          o_closed_nxt = 1'b0;
          o_len_nxt    = '0;
          o_ppk_nxt    = '0;
          o_last_nxt   = last_r;
          if (bars_r != '0) begin
            open_pk_nxt = open_upd;
            if ((is_zero || last_r) && bars_r > CNT_ONE) begin
              o_closed_nxt = 1'b1;
              o_len_nxt    = bars_r;
              o_ppk_nxt    = open_upd;
            end
          end
          if (is_zero) begin
            bars_nxt    = CNT_ONE;
            open_pk_nxt = '0;
          end else if (bars_r != '0 && bars_r != CNT_MAX) begin
            bars_nxt = bars_r + CNT_ONE;
          end
          if (last_r) begin
            peak_nxt    = '0;
            first_nxt   = 1'b1;
            bars_nxt    = '0;
            open_pk_nxt = '0;
            max_dd_nxt  = '0;
          end
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      peak_r      <= '0;
      first_r     <= 1'b1;
      bars_r      <= '0;
      open_pk_r   <= '0;
      max_dd_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      peak_r      <= peak_nxt;
      first_r     <= first_nxt;
      bars_r      <= bars_nxt;
      open_pk_r   <= open_pk_nxt;
      max_dd_r    <= max_dd_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    eq_r       <= eq_nxt;
    last_r     <= last_nxt;
    rem_r      <= rem_nxt;
    quo_r      <= quo_nxt;
    o_dd_r     <= o_dd_nxt;
    o_closed_r <= o_closed_nxt;
    o_len_r    <= o_len_nxt;
    o_ppk_r    <= o_ppk_nxt;
    o_max_r    <= o_max_nxt;
    o_last_r   <= o_last_nxt;
  end

  assign out_valid                = out_valid_r;
  assign out_drawdown_frac        = o_dd_r;
  assign out_period_closed        = o_closed_r;
  assign out_period_length        = o_len_r;
  assign out_period_peak_drawdown = o_ppk_r;
  assign out_series_max_drawdown  = o_max_r;
  assign out_last_of_series       = o_last_r;

endmodule

// File: sv/ddpt_checker.sv
// ----------------------------------------------------------------------------
// ddpt_checker
// Port-level checks for the drawdown period tracker, bound into every instance.
// ----------------------------------------------------------------------------
module ddpt_checker
  import ddpt_pkg::*;
#(
  parameter int FRAC_BITS   = FRAC_BITS_DEF,
  parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_stall,
  input logic                   out_valid,
  input logic                   out_stall,
  input logic [FRAC_BITS:0]     out_drawdown_frac,
  input logic                   out_period_closed,
  input logic [COUNT_BITS-1:0]  out_period_length,
  input logic [FRAC_BITS:0]     out_period_peak_drawdown,
  input logic [FRAC_BITS:0]     out_series_max_drawdown
);

  localparam logic [FRAC_BITS:0]    DD_ONE  = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);

  // one transaction at a time: busy right after acceptance
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted while previous transaction in flight");

  a_dd_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_drawdown_frac <= DD_ONE &&
                   out_series_max_drawdown >= out_drawdown_frac))
    else $error("drawdown out of range or above series maximum");

  a_closed_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_period_closed) |->
      (out_period_length > CNT_ONE &&
       out_period_peak_drawdown <= out_series_max_drawdown))
    else $error("closed period fields inconsistent");

  a_open_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_period_closed) |->
      (out_period_length == '0 && out_period_peak_drawdown == '0))
    else $error("period fields nonzero without a closed period");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_drawdown_frac)))
    else $error("stalled result changed");

endmodule

bind drawdown_period_tracker ddpt_checker #(
  .FRAC_BITS  (FRAC_BITS),
  .COUNT_BITS (COUNT_BITS)
) u_ddpt_checker (
  .clk                      (clk),
  .rst_n                    (rst_n),
  .in_valid                 (in_valid),
  .in_stall                 (in_stall),
  .out_valid                (out_valid),
  .out_stall                (out_stall),
  .out_drawdown_frac        (out_drawdown_frac),
  .out_period_closed        (out_period_closed),
  .out_period_length        (out_period_length),
  .out_period_peak_drawdown (out_period_peak_drawdown),
  .out_series_max_drawdown  (out_series_max_drawdown)
);

// File: tb/sv/drawdown_period_tracker_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drawdown_period_tracker_test
// Self-checking bench for the drawdown period tracker. Equity bars are sent
// as directed corner cases and then as random series and noise, under
// several sender/receiver stall mixes. A scoreboard predicts each bar's
// drawdown result and checks every result transaction field by field.
// ----------------------------------------------------------------------------
module drawdown_period_tracker_test;
  import ddpt_pkg::*;

  localparam int EQ_W  = EQUITY_BITS_DEF;
  localparam int FRAC_W = FRAC_BITS_DEF;
  localparam int CNT_W = COUNT_BITS_DEF;
  localparam int STALL_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 60;

  typedef logic [EQ_W-1:0]  equity_t;
  typedef logic [FRAC_W:0]  frac_t;
  typedef logic [CNT_W-1:0] count_t;

  localparam equity_t EQ_MAX = '1;
  localparam frac_t DD_ONE = frac_t'(1) << FRAC_W;

  typedef struct packed {
    frac_t  drawdown;
    logic   closed;
    count_t length;
    frac_t  period_peak;
    frac_t  series_max;
    logic   last;
  } drawdown_result_t;

  class tracker_scoreboard;
    equity_t          peak;
    logic             first_pending = 1'b1;
    count_t           bars_since_zero;
    frac_t            open_peak;
    frac_t            max_dd;
    drawdown_result_t expected_q[$];
    int               errors;

    function void clear_series();
      peak            = '0;
      first_pending   = 1'b1;
      bars_since_zero = '0;
      open_peak       = '0;
      max_dd          = '0;
    endfunction

    // Predict the result for one accepted bar.
    function void note_bar(equity_t eq, logic last);
      drawdown_result_t r;
      logic [63:0]      num;
      logic [63:0]      quo;
      frac_t            dd;
      logic             is_zero;
      r = '0;
      if (first_pending) begin
        peak            = eq;
        bars_since_zero = '0;
        open_peak       = '0;
        max_dd          = '0;
        first_pending   = 1'b0;
      end else if (eq > peak) begin
        peak = eq;
      end
      if (peak == '0) begin
        dd      = DD_ONE;
        is_zero = 1'b0;
      end else begin
        num     = 64'(peak - eq) << FRAC_W;
        quo     = num / 64'(peak);
        dd      = quo[FRAC_W:0];
        is_zero = (eq == peak);
      end
      if (dd > max_dd) max_dd = dd;
      if (bars_since_zero != '0) begin
        if (dd > open_peak) open_peak = dd;
        if ((is_zero || last) && bars_since_zero > 1) begin
          r.closed      = 1'b1;
          r.length      = bars_since_zero;
          r.period_peak = open_peak;
        end
      end
      if (is_zero) begin
        bars_since_zero = count_t'(1);
        open_peak       = '0;
      end else if (bars_since_zero != '0 && bars_since_zero != '1) begin
        bars_since_zero++;
      end
      r.drawdown   = dd;
      r.series_max = max_dd;
      r.last       = last;
      expected_q = {expected_q, r};
      if (last) clear_series();
    endfunction

    function void cmp_field(string name, logic [63:0] expv, logic [63:0] actv);
      if (expv !== actv) begin
        $error("%s: expected %0d, actual %0d", name, expv, actv);
        errors++;
      end
    endfunction

    function void check_result(drawdown_result_t act);
      drawdown_result_t exp_r;
      if (expected_q.size() == 0) begin
        $error("result transaction with nothing expected");
        errors++;
        return;
      end
      exp_r = expected_q.pop_front();
      cmp_field("drawdown_frac", 64'(exp_r.drawdown), 64'(act.drawdown));
      cmp_field("period_closed", 64'(exp_r.closed), 64'(act.closed));
      cmp_field("period_length", 64'(exp_r.length), 64'(act.length));
      cmp_field("period_peak_drawdown", 64'(exp_r.period_peak), 64'(act.period_peak));
      cmp_field("series_max_drawdown", 64'(exp_r.series_max), 64'(act.series_max));
      cmp_field("last_of_series", 64'(exp_r.last), 64'(act.last));
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic    clk = 1'b0;
  logic    rst_n = 1'b0;
  logic    in_valid = 1'b0;
  logic    in_stall;
  equity_t in_equity_value = '0;
  logic    in_series_end = 1'b0;
  logic    out_valid;
  logic    out_stall = 1'b0;
  frac_t   out_drawdown_frac;
  logic    out_period_closed;
  count_t  out_period_length;
  frac_t   out_period_peak_drawdown;
  frac_t   out_series_max_drawdown;
  logic    out_last_of_series;

  tracker_scoreboard sb;
  int idle_pct;
  int stall_pct;
  int bars_sent;
  int quiet_cycles;

  drawdown_period_tracker dut (
    .clk                      (clk),
    .rst_n                    (rst_n),
    .in_valid                 (in_valid),
    .in_stall                 (in_stall),
    .in_equity_value          (in_equity_value),
    .in_series_end            (in_series_end),
    .out_valid                (out_valid),
    .out_stall                (out_stall),
    .out_drawdown_frac        (out_drawdown_frac),
    .out_period_closed        (out_period_closed),
    .out_period_length        (out_period_length),
    .out_period_peak_drawdown (out_period_peak_drawdown),
    .out_series_max_drawdown  (out_series_max_drawdown),
    .out_last_of_series       (out_last_of_series)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Transaction monitor, receiver stall and watchdog. Reads pre-edge values.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_bar(in_equity_value, in_series_end);
      if (out_valid && !out_stall)
        sb.check_result('{out_drawdown_frac, out_period_closed, out_period_length,
                          out_period_peak_drawdown, out_series_max_drawdown,
                          out_last_of_series});
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
          $display("drawdown_period_tracker verification failed");
          $finish;
        end
      end
    end
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  function automatic equity_t rand_equity(int bits);
    logic [63:0] r;
    r = {$urandom, $urandom};
    return equity_t'(r >> (64 - bits));
  endfunction

  task automatic send_bar(equity_t eq, logic last);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_equity_value <= eq;
    in_series_end   <= last;
    do @(posedge clk); while (in_stall);
    bars_sent++;
  endtask

  // A well-formed series: new highs, returns to the peak, dips and wipe-outs.
  task automatic send_series();
    int          len;
    int          bits;
    int          pick;
    equity_t     pk;
    equity_t     eq;
    logic [63:0] tmp;
    len  = $urandom_range(1, 24);
    bits = $urandom_range(1, EQ_W);
    pk   = rand_equity(bits);
    for (int i = 0; i < len; i++) begin
      pick = $urandom_range(0, 99);
      if (i == 0 || pick < 25) begin
        eq = pk;
      end else if (pick < 40) begin
        tmp = 64'(pk) + 64'(rand_equity($urandom_range(1, bits))) + 1;
        eq  = (tmp > 64'(EQ_MAX)) ? EQ_MAX : equity_t'(tmp);
        pk  = eq;
      end else if (pick < 45) begin
        eq = '0;
      end else if (pick < 52) begin
        eq = (pk != '0) ? pk - 1 : pk;
      end else begin
        tmp = (64'(pk) * 64'($urandom_range(0, 1023))) >> 10;
        eq  = equity_t'(tmp);
      end
      send_bar(eq, i == len - 1);
    end
  endtask

  task automatic send_noise();
    int n;
    n = $urandom_range(1, 6);
    repeat (n) send_bar(rand_equity($urandom_range(1, EQ_W)), $urandom_range(0, 3) == 0);
  endtask

  task automatic run_random(int count);
    int target;
    target = bars_sent + count;
    while (bars_sent < target) begin
      if ($urandom_range(0, 9) == 0) send_noise();
      else send_series();
    end
  endtask

  initial begin
    sb = new();
    idle_pct  = 0;
    stall_pct = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero peak, then a real peak with a one-bar period
    send_bar('0, 1'b0);
    send_bar('0, 1'b0);
    send_bar(100, 1'b0);
    send_bar(100, 1'b0);
    // dip to half and to nothing, closed by return to peak
    send_bar(50, 1'b0);
    send_bar('0, 1'b0);
    send_bar(100, 1'b0);
    // full-scale peak, period closed by series end
    send_bar(EQ_MAX, 1'b0);
    send_bar(EQ_MAX - 1, 1'b0);
    send_bar(1, 1'b0);
    send_bar('0, 1'b1);
    // single-bar series
    send_bar(EQ_MAX, 1'b1);
    send_bar('0, 1'b1);
    // period closed by a new high, then one-bar periods at the end
    send_bar(7, 1'b0);
    send_bar(3, 1'b0);
    send_bar(5, 1'b0);
    send_bar(9, 1'b0);
    send_bar(9, 1'b1);
    send_bar(1, 1'b0);
    send_bar('0, 1'b1);

    run_random(130);
    idle_pct = 63;
    run_random(150);
    idle_pct  = 0;
    stall_pct = 63;
    run_random(150);
    idle_pct  = 38;
    stall_pct = 38;
    run_random(150);
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("drawdown_period_tracker verification clean");
    end else begin
      $display("drawdown_period_tracker verification failed");
    end
    $finish;
  end

endmodule
